FILE: src/bts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texel sampler package
// Shared types, codes and constants for the texel sampler unit.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_BLEND_BITS = 8;

    localparam int CFG_DIM_W   = 9;
    localparam int CH_CNT_W    = 3;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;
    localparam int PIX_WORD_W  = CHAN_W * NUM_CHAN;
    localparam int COORD_W     = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int DEF_RAM_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = 9'd256;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = 9'd256;
    localparam logic [CH_CNT_W-1:0]  RST_CHANNEL_COUNT = 3'd4;
    localparam logic [CH_CNT_W-1:0]  MAX_CHANNELS      = 3'd4;
    localparam logic [CHAN_W-1:0]    ALPHA_DEFAULT     = 8'd255;
    localparam int                   ALPHA_CHAN        = 3;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_SAMPLE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic [CHAN_W-1:0]  write_red;
        logic [CHAN_W-1:0]  write_green;
        logic [CHAN_W-1:0]  write_blue;
        logic [CHAN_W-1:0]  write_alpha;
        logic [COORD_W-1:0] coord_u;
        logic [COORD_W-1:0] coord_v;
    } t_in_item;

    typedef struct packed {
        logic [CHAN_W-1:0] result_red;
        logic [CHAN_W-1:0] result_green;
        logic [CHAN_W-1:0] result_blue;
        logic [CHAN_W-1:0] result_alpha;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       access;
        logic       we;
        logic [1:0] idx;
        logic       acc;
        logic       fin;
    } t_dp_cmd;

    // Kind of the item held in the datapath.
    typedef struct packed {
        logic is_write;
        logic is_read;
        logic is_sample;
    } t_dp_stat;

endpackage

FILE: src/bilinear_texel_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texel sampler unit
// Pixel store with write, read and bilinear sample commands, configured over
// an APB-style register port.
// ----------------------------------------------------------------------------
// Each accepted item keeps the unit busy through its memory accesses, and a
// read or sample also through a finishing state; a sample makes four reads
// from the single-port pixel memory; no new item is taken while busy.
// Reset clears the control state and sets the registers to 256 x 256 pixels
// and four channels; the pixel memory is not cleared and has no clearing pass.
// Results are strobed for one cycle and cannot be held off by the receiver.
module bilinear_texel_sampler_unit #(
    parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
    parameter int BLEND_BITS = bts_pkg::DEF_BLEND_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bts_pkg::t_in_item                i_item,
    output bts_pkg::t_out_item               o_result,
    output logic                             o_result_valid,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bts_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bts_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bts_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int DW = bts_pkg::CFG_DIM_W;
    localparam int NW = bts_pkg::CH_CNT_W;

    logic [DW-1:0] r_image_width, r_image_height;
    logic [NW-1:0] r_channel_count;
    logic [1:0]    w_reg_idx;

    assign w_reg_idx = paddr[3:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= bts_pkg::RST_IMAGE_WIDTH;
            r_image_height  <= bts_pkg::RST_IMAGE_HEIGHT;
            r_channel_count <= bts_pkg::RST_CHANNEL_COUNT;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                bts_pkg::REG_IMAGE_WIDTH:   r_image_width   <= pwdata[DW-1:0];
                bts_pkg::REG_IMAGE_HEIGHT:  r_image_height  <= pwdata[DW-1:0];
                bts_pkg::REG_CHANNEL_COUNT: r_channel_count <= pwdata[NW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            bts_pkg::REG_IMAGE_WIDTH:   prdata = bts_pkg::APB_DATA_W'(r_image_width);
            bts_pkg::REG_IMAGE_HEIGHT:  prdata = bts_pkg::APB_DATA_W'(r_image_height);
            bts_pkg::REG_CHANNEL_COUNT: prdata = bts_pkg::APB_DATA_W'(r_channel_count);
            default:                    prdata = '0;
        endcase
    end

    // Register values outside their range are clamped onto it.
    logic [DW-1:0] w_eff_width, w_eff_height;
    logic [NW-1:0] w_eff_channels;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff_width = DW'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_eff_width = DW'(MAX_WIDTH);
        end else begin
            w_eff_width = r_image_width;
        end
        if (r_image_height == '0) begin
            w_eff_height = DW'(1);
        end else if (int'(r_image_height) > MAX_HEIGHT) begin
            w_eff_height = DW'(MAX_HEIGHT);
        end else begin
            w_eff_height = r_image_height;
        end
        if (r_channel_count == '0) begin
            w_eff_channels = NW'(1);
        end else if (r_channel_count > bts_pkg::MAX_CHANNELS) begin
            w_eff_channels = bts_pkg::MAX_CHANNELS;
        end else begin
            w_eff_channels = r_channel_count;
        end
    end

    bts_pkg::t_dp_cmd  w_cmd;
    bts_pkg::t_dp_stat w_stat;

    bts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    bts_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .BLEND_BITS (BLEND_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_item         (i_item),
        .i_eff_width    (w_eff_width),
        .i_eff_height   (w_eff_height),
        .i_eff_channels (w_eff_channels),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule

FILE: src/bts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = bts_pkg::PIX_WORD_W,
    parameter int DEPTH = bts_pkg::DEF_RAM_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel sampler controller
// Sequences the memory accesses of one item and tells the datapath when to
// load, accumulate and finish.
// ----------------------------------------------------------------------------
module bts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_command,
    input  bts_pkg::t_dp_stat  i_stat,
    output bts_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);

    bts_pkg::t_state r_state, n_state;
    logic [1:0]      r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bts_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            bts_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                n_idx  = '0;
                // An unknown command is taken and dropped without any work.
                if (i_start && (i_command == bts_pkg::CMD_WRITE ||
                                i_command == bts_pkg::CMD_READ ||
                                i_command == bts_pkg::CMD_SAMPLE)) begin
                    o_cmd.load = 1'b1;
                    n_state    = bts_pkg::ST_ACCESS;
                end
            end
            bts_pkg::ST_ACCESS: begin
                o_cmd.access = 1'b1;
                o_cmd.idx    = r_idx;
                o_cmd.we     = i_stat.is_write;
                // Data of the previous texel arrives while the next is fetched.
                o_cmd.acc    = (r_idx != 2'd0);
                if (i_stat.is_write) begin
                    n_state = bts_pkg::ST_IDLE;
                end else if (i_stat.is_read || r_idx == 2'd3) begin
                    n_state = bts_pkg::ST_FIN;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            bts_pkg::ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = bts_pkg::ST_IDLE;
            end
            default: begin
                n_state = bts_pkg::ST_IDLE;
            end
        endcase
    end

    a_fin_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bts_pkg::ST_FIN) |=> (r_state == bts_pkg::ST_IDLE))
        else $error("controller did not return to idle after finishing");

    a_fin_after_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> $past(o_cmd.access))
        else $error("finish without a preceding memory access");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command == bts_pkg::CMD_SAMPLE)
        |=> (o_cmd.access && o_cmd.idx == 2'd0 && i_stat.is_sample))
        else $error("accepted sample did not start at its first texel");

    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.we |-> (o_cmd.idx == 2'd0 && !o_cmd.acc))
        else $error("pixel write issued outside the first access");

endmodule

FILE: src/bts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel sampler datapath
// Position and blend fraction, pixel memory, per-texel weights and the four
// channel accumulators.
// ----------------------------------------------------------------------------
module bts_dp #(
    parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT,
    parameter int BLEND_BITS = bts_pkg::DEF_BLEND_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bts_pkg::t_dp_cmd                 i_cmd,
    output bts_pkg::t_dp_stat                o_stat,
    input  bts_pkg::t_in_item                i_item,
    input  logic [bts_pkg::CFG_DIM_W-1:0]    i_eff_width,
    input  logic [bts_pkg::CFG_DIM_W-1:0]    i_eff_height,
    input  logic [bts_pkg::CH_CNT_W-1:0]     i_eff_channels,
    output bts_pkg::t_out_item               o_result,
    output logic                             o_result_valid
);

    localparam int DW     = bts_pkg::CFG_DIM_W;
    localparam int CW     = bts_pkg::CHAN_W;
    localparam int NCH    = bts_pkg::NUM_CHAN;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PU_W   = bts_pkg::COORD_W + DW;
    localparam int MUL_W  = 2 * DW;
    localparam int WF_W   = BLEND_BITS + 1;
    localparam int WP_W   = 2 * WF_W;
    localparam int WGT_W  = 2 * BLEND_BITS + 1;
    localparam int ACC_W  = 2 * BLEND_BITS + CW + 1;
    localparam logic [WF_W-1:0]  SCALE = WF_W'(1) << BLEND_BITS;
    localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (2 * BLEND_BITS - 1);

    function automatic logic [DW-1:0] f_clamp(input logic [DW-1:0] v,
                                              input logic [DW-1:0] lim);
        return (v >= lim) ? lim - DW'(1) : v;
    endfunction

    // Item registers.
    logic [DW-1:0]              r_x0, r_x1, r_y0, r_y1;
    logic [BLEND_BITS-1:0]      r_fx, r_fy;
    logic [bts_pkg::PIX_WORD_W-1:0] r_wdata;
    logic [WGT_W-1:0]           r_wgt;
    logic [NCH-1:0][ACC_W-1:0]  r_acc;
    bts_pkg::t_out_item         r_res;
    logic                       r_valid;
    bts_pkg::t_dp_stat          r_stat;

    // Load-cycle position arithmetic.
    logic [PU_W-1:0]       w_pu, w_pv;
    logic [DW-1:0]         w_sx0, w_sy0, w_x0, w_y0, w_x1, w_y1;
    logic                  w_is_sample;

    assign w_is_sample = (i_item.command == bts_pkg::CMD_SAMPLE);
    assign w_pu  = PU_W'(i_item.coord_u) * PU_W'(i_eff_width);
    assign w_pv  = PU_W'(i_item.coord_v) * PU_W'(i_eff_height);
    assign w_sx0 = f_clamp(w_pu[PU_W-1:bts_pkg::COORD_W], i_eff_width);
    assign w_sy0 = f_clamp(w_pv[PU_W-1:bts_pkg::COORD_W], i_eff_height);

    always_comb begin
        if (w_is_sample) begin
            w_x0 = w_sx0;
            w_y0 = w_sy0;
        end else begin
            w_x0 = f_clamp(DW'(i_item.pixel_x), i_eff_width);
            w_y0 = f_clamp(DW'(i_item.pixel_y), i_eff_height);
        end
    end

    // The base is at most width-1, so the increment cannot overflow.
    assign w_x1 = f_clamp(w_x0 + DW'(1), i_eff_width);
    assign w_y1 = f_clamp(w_y0 + DW'(1), i_eff_height);

    // Access-cycle address and weight of the selected neighbour.
    logic [DW-1:0]      w_tx, w_ty;
    logic [MUL_W:0]     w_lin;
    logic [ADDR_W-1:0]  w_addr;
    logic [WF_W-1:0]    w_wx, w_wy;
    logic [WP_W-1:0]    w_wprod;

    assign w_tx    = i_cmd.idx[0] ? r_x1 : r_x0;
    assign w_ty    = i_cmd.idx[1] ? r_y1 : r_y0;
    assign w_lin   = (MUL_W+1)'(MUL_W'(w_ty) * MUL_W'(i_eff_width)) + (MUL_W+1)'(w_tx);
    assign w_addr  = ADDR_W'(w_lin);
    assign w_wx    = i_cmd.idx[0] ? WF_W'(r_fx) : SCALE - WF_W'(r_fx);
    assign w_wy    = i_cmd.idx[1] ? WF_W'(r_fy) : SCALE - WF_W'(r_fy);
    assign w_wprod = WP_W'(w_wx) * WP_W'(w_wy);

    logic [bts_pkg::PIX_WORD_W-1:0] w_rdata;

    bts_ram #(
        .WIDTH (bts_pkg::PIX_WORD_W),
        .DEPTH (DEPTH)
    ) u_pixel_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.access && i_cmd.we),
        .i_addr  (w_addr),
        .i_wdata (r_wdata),
        .o_rdata (w_rdata)
    );

    // Channels beyond the configured count take their default value before
    // blending, so every neighbour carries the same default.
    logic [NCH-1:0][CW-1:0]    w_texel;
    logic [NCH-1:0][ACC_W-1:0] w_sum;

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            if (i < int'(i_eff_channels)) begin
                w_texel[i] = w_rdata[CW*i +: CW];
            end else if (i == bts_pkg::ALPHA_CHAN) begin
                w_texel[i] = bts_pkg::ALPHA_DEFAULT;
            end else begin
                w_texel[i] = '0;
            end
            w_sum[i] = r_acc[i] + ACC_W'(ACC_W'(w_texel[i]) * ACC_W'(r_wgt));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0    <= w_x0;
            r_y0    <= w_y0;
            r_x1    <= w_x1;
            r_y1    <= w_y1;
            r_fx    <= w_is_sample ? w_pu[bts_pkg::COORD_W-1 -: BLEND_BITS] : '0;
            r_fy    <= w_is_sample ? w_pv[bts_pkg::COORD_W-1 -: BLEND_BITS] : '0;
            r_wdata <= {i_item.write_alpha, i_item.write_blue,
                        i_item.write_green, i_item.write_red};
            for (int i = 0; i < NCH; i++) begin
                r_acc[i] <= ROUND;
            end
        end
        if (i_cmd.access) begin
            r_wgt <= w_wprod[WGT_W-1:0];
        end
        if (i_cmd.acc) begin
            r_acc <= w_sum;
        end
        if (i_cmd.fin) begin
            r_res.result_red   <= w_sum[0][2*BLEND_BITS +: CW];
            r_res.result_green <= w_sum[1][2*BLEND_BITS +: CW];
            r_res.result_blue  <= w_sum[2][2*BLEND_BITS +: CW];
            r_res.result_alpha <= w_sum[3][2*BLEND_BITS +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_stat  <= '0;
        end else begin
            r_valid <= i_cmd.fin;
            if (i_cmd.load) begin
                r_stat.is_write  <= (i_item.command == bts_pkg::CMD_WRITE);
                r_stat.is_read   <= (i_item.command == bts_pkg::CMD_READ);
                r_stat.is_sample <= w_is_sample;
            end
        end
    end

    assign o_stat         = r_stat;
    assign o_result       = r_res;
    assign o_result_valid = r_valid;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear texel sampler unit testbench
// Drives write, read and sample commands through the start/busy port and
// checks every strobed colour against a fixed-point predictor of the pixel
// store. A directed list comes first, then random phases under a range of
// image sizes and channel counts set over the register port.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          MAX_W           = bts_pkg::DEF_MAX_WIDTH;
    localparam int          MAX_H           = bts_pkg::DEF_MAX_HEIGHT;
    localparam int          BLEND           = bts_pkg::DEF_BLEND_BITS;
    localparam logic [1:0]  CMD_UNUSED      = 2'd3;
    localparam int          NUM_PHASES      = 12;
    localparam int          ITEMS_PER_PHASE = 58;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT  = 1000;
    localparam int          REPORT_LIMIT    = 10;

    typedef logic [bts_pkg::NUM_CHAN-1:0][bts_pkg::CHAN_W-1:0] t_quad;

    typedef struct {
        bit                 is_reg;
        bts_pkg::t_reg_idx  reg_idx;
        logic [31:0]        reg_val;
        bts_pkg::t_in_item  item;
        bit                 known;
        logic [31:0]        want;
    } t_plan_row;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start   = 1'b0;
    logic                           busy;
    bts_pkg::t_in_item              i_item  = '0;
    bts_pkg::t_out_item             o_result;
    logic                           o_result_valid;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [bts_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [bts_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [bts_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Predictor state: the image store and the raw register contents.
    logic [bts_pkg::PIX_WORD_W-1:0] pix_mem     [bts_pkg::DEF_RAM_DEPTH];
    bit                             pix_written [bts_pkg::DEF_RAM_DEPTH];
    int unsigned                    cfg_width  = bts_pkg::RST_IMAGE_WIDTH;
    int unsigned                    cfg_height = bts_pkg::RST_IMAGE_HEIGHT;
    int unsigned                    cfg_chans  = bts_pkg::RST_CHANNEL_COUNT;

    bts_pkg::t_out_item expected_colours [$];
    t_plan_row          plan [$];
    bts_pkg::t_out_item colour_due;
    int unsigned gap_pct        = 14;
    int unsigned fault_count    = 0;
    int unsigned results_seen   = 0;
    int unsigned items_done     = 0;
    int unsigned writes_done    = 0;
    int unsigned reads_done     = 0;
    int unsigned samples_done   = 0;
    int unsigned ignored_done   = 0;
    int unsigned settings_done  = 0;
    int unsigned quiet_cycles   = 0;

    bilinear_texel_sampler_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned top);
        if (raw == 0) return 1;
        return (raw > top) ? top : raw;
    endfunction

    function automatic int unsigned eff_width();
        return eff_dim(cfg_width, MAX_W);
    endfunction

    function automatic int unsigned eff_height();
        return eff_dim(cfg_height, MAX_H);
    endfunction

    function automatic int unsigned eff_chans();
        return eff_dim(cfg_chans, bts_pkg::MAX_CHANNELS);
    endfunction

    function automatic int unsigned clamp_edge(input int unsigned v, input int unsigned lim);
        return (v >= lim) ? lim - 1 : v;
    endfunction

    function automatic int unsigned pixel_addr(input int unsigned x, input int unsigned y);
        return y * eff_width() + x;
    endfunction

    // One stored pixel, with absent channels replaced by their defaults.
    function automatic t_quad texel(input int unsigned x, input int unsigned y);
        logic [bts_pkg::PIX_WORD_W-1:0] word;
        t_quad                          q;
        word = pix_mem[pixel_addr(x, y)];
        for (int i = 0; i < bts_pkg::NUM_CHAN; i++) begin
            if (i < eff_chans())
                q[i] = word[bts_pkg::CHAN_W*i +: bts_pkg::CHAN_W];
            else
                q[i] = (i == bts_pkg::ALPHA_CHAN) ? bts_pkg::ALPHA_DEFAULT : '0;
        end
        return q;
    endfunction

    function automatic void sample_corners(input logic [bts_pkg::COORD_W-1:0] u,
                                           input logic [bts_pkg::COORD_W-1:0] v,
                                           output int unsigned x0, output int unsigned x1,
                                           output int unsigned y0, output int unsigned y1,
                                           output int unsigned fx, output int unsigned fy);
        logic [31:0] pu;
        logic [31:0] pv;
        pu = u * eff_width();
        pv = v * eff_height();
        fx = pu[15:0] >> (bts_pkg::COORD_W - BLEND);
        fy = pv[15:0] >> (bts_pkg::COORD_W - BLEND);
        x0 = clamp_edge(pu >> bts_pkg::COORD_W, eff_width());
        y0 = clamp_edge(pv >> bts_pkg::COORD_W, eff_height());
        x1 = clamp_edge(x0 + 1, eff_width());
        y1 = clamp_edge(y0 + 1, eff_height());
    endfunction

    // Applies one accepted item to the predicted store; returns 1 when the
    // item produces a colour.
    function automatic bit predict_colour(input bts_pkg::t_in_item it,
                                          output bts_pkg::t_out_item res);
        int unsigned       x, y, x0, x1, y0, y1, fx, fy;
        t_quad             a, b, c, d, q;
        longint unsigned   top, bot, acc, r, s;
        s = longint'(1) << BLEND;
        res = '0;
        x = clamp_edge(it.pixel_x, eff_width());
        y = clamp_edge(it.pixel_y, eff_height());
        case (it.command)
            bts_pkg::CMD_WRITE: begin
                pix_mem[pixel_addr(x, y)] = {it.write_alpha, it.write_blue,
                                             it.write_green, it.write_red};
                pix_written[pixel_addr(x, y)] = 1'b1;
                return 1'b0;
            end
            bts_pkg::CMD_READ: begin
                q = texel(x, y);
            end
            bts_pkg::CMD_SAMPLE: begin
                sample_corners(it.coord_u, it.coord_v, x0, x1, y0, y1, fx, fy);
                a = texel(x0, y0);
                b = texel(x1, y0);
                c = texel(x0, y1);
                d = texel(x1, y1);
                for (int i = 0; i < bts_pkg::NUM_CHAN; i++) begin
                    top = a[i] * (s - fx) + b[i] * fx;
                    bot = c[i] * (s - fx) + d[i] * fx;
                    acc = top * (s - fy) + bot * fy + ((s * s) >> 1);
                    r = acc >> (2 * BLEND);
                    q[i] = (r > 255) ? 8'hFF : r[7:0];
                end
            end
            default: return 1'b0;
        endcase
        // The result struct carries red in its top byte.
        res = {q[0], q[1], q[2], q[3]};
        return 1'b1;
    endfunction

    function automatic bts_pkg::t_in_item make_item(input logic [1:0] cmd,
                                                    input logic [7:0] x,
                                                    input logic [7:0] y,
                                                    input logic [31:0] rgba,
                                                    input logic [bts_pkg::COORD_W-1:0] u,
                                                    input logic [bts_pkg::COORD_W-1:0] v);
        bts_pkg::t_in_item it;
        it.command     = cmd;
        it.pixel_x     = x;
        it.pixel_y     = y;
        it.write_red   = rgba[31:24];
        it.write_green = rgba[23:16];
        it.write_blue  = rgba[15:8];
        it.write_alpha = rgba[7:0];
        it.coord_u     = u;
        it.coord_v     = v;
        return it;
    endfunction

    function automatic void plan_cmd(input bts_pkg::t_in_item it, input bit known,
                                     input logic [31:0] want);
        t_plan_row row;
        row.is_reg  = 1'b0;
        row.reg_idx = bts_pkg::REG_IMAGE_WIDTH;
        row.reg_val = '0;
        row.item    = it;
        row.known   = known;
        row.want    = want;
        plan = {plan, row};
    endfunction

    function automatic void plan_reg(input bts_pkg::t_reg_idx idx, input logic [31:0] val);
        t_plan_row row;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        row.item    = '0;
        row.known   = 1'b0;
        row.want    = '0;
        plan = {plan, row};
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [bts_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return bts_pkg::COORD_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_dim();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(511, 257);
            2:       return 256;
            3:       return $urandom_range(255, 17);
            default: return $urandom_range(16, 1);
        endcase
    endfunction

    function automatic bts_pkg::t_in_item rand_item();
        bts_pkg::t_in_item it;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 35)
            it.command = bts_pkg::CMD_WRITE;
        else if (pick < 60)
            it.command = bts_pkg::CMD_READ;
        else if (pick < 96)
            it.command = bts_pkg::CMD_SAMPLE;
        else
            it.command = CMD_UNUSED;
        // Mostly inside the image; the rest exercises edge clamping.
        it.pixel_x = ($urandom_range(3) != 0) ? 8'($urandom_range(eff_width() - 1))
                                               : 8'($urandom);
        it.pixel_y = ($urandom_range(3) != 0) ? 8'($urandom_range(eff_height() - 1))
                                               : 8'($urandom);
        it.write_red   = pick_byte();
        it.write_green = pick_byte();
        it.write_blue  = pick_byte();
        it.write_alpha = pick_byte();
        it.coord_u     = pick_coord();
        it.coord_v     = pick_coord();
        return it;
    endfunction

    function automatic void report_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    task automatic send_item(input bts_pkg::t_in_item it, input bit known,
                             input logic [31:0] want);
        bts_pkg::t_out_item due;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (predict_colour(it, due))
            expected_colours = {expected_colours,
                                (known ? bts_pkg::t_out_item'(want) : due)};
        case (it.command)
            bts_pkg::CMD_WRITE:  writes_done++;
            bts_pkg::CMD_READ:   reads_done++;
            bts_pkg::CMD_SAMPLE: samples_done++;
            default:             ignored_done++;
        endcase
        if (it.command != CMD_UNUSED)
            items_done++;
    endtask

    // Writes any pixel the item would fetch that has never been stored, so
    // that no read ever reaches an undefined word.
    task automatic send_with_fill(input bts_pkg::t_in_item it);
        int unsigned       xs [4];
        int unsigned       ys [4];
        int unsigned       n, x0, x1, y0, y1, fx, fy;
        bts_pkg::t_in_item fill;
        n = 0;
        if (it.command == bts_pkg::CMD_READ) begin
            xs[0] = clamp_edge(it.pixel_x, eff_width());
            ys[0] = clamp_edge(it.pixel_y, eff_height());
            n = 1;
        end else if (it.command == bts_pkg::CMD_SAMPLE) begin
            sample_corners(it.coord_u, it.coord_v, x0, x1, y0, y1, fx, fy);
            xs = '{x0, x1, x0, x1};
            ys = '{y0, y0, y1, y1};
            n = 4;
        end
        for (int k = 0; k < n; k++) begin
            if (!pix_written[pixel_addr(xs[k], ys[k])]) begin
                fill = rand_item();
                fill.command = bts_pkg::CMD_WRITE;
                fill.pixel_x = 8'(xs[k]);
                fill.pixel_y = 8'(ys[k]);
                send_item(fill, 1'b0, '0);
            end
        end
        send_item(it, 1'b0, '0);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_colours.size() != 0 || busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register with junk above its width, then reads it back.
    task automatic write_reg(input bts_pkg::t_reg_idx idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] stored;
        logic [31:0] readback;
        mask   = (idx == bts_pkg::REG_CHANNEL_COUNT) ? (32'd1 << bts_pkg::CH_CNT_W) - 1
                                                     : (32'd1 << bts_pkg::CFG_DIM_W) - 1;
        stored = value & mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~mask) | stored;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            bts_pkg::REG_IMAGE_WIDTH:  cfg_width  = stored;
            bts_pkg::REG_IMAGE_HEIGHT: cfg_height = stored;
            default:                   cfg_chans  = stored;
        endcase
        settings_done++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (readback !== stored)
            report_fault($sformatf("register %s read back %h, expected %h",
                                   idx.name(), readback, stored));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_colours.size() == 0) begin
                report_fault($sformatf("unexpected colour r=%h g=%h b=%h a=%h",
                                       o_result.result_red, o_result.result_green,
                                       o_result.result_blue, o_result.result_alpha));
            end else begin
                colour_due = expected_colours.pop_front();
                results_seen++;
                if (o_result.result_red   !== colour_due.result_red   ||
                    o_result.result_green !== colour_due.result_green ||
                    o_result.result_blue  !== colour_due.result_blue  ||
                    o_result.result_alpha !== colour_due.result_alpha)
                    report_fault($sformatf(
                        "colour %0d: expected r=%h g=%h b=%h a=%h, got r=%h g=%h b=%h a=%h",
                        results_seen, colour_due.result_red, colour_due.result_green,
                        colour_due.result_blue, colour_due.result_alpha,
                        o_result.result_red, o_result.result_green,
                        o_result.result_blue, o_result.result_alpha));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, giving up", WATCHDOG_LIMIT);
            $display("bilinear_texel_sampler_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned phase_end;
        int unsigned dim_w, dim_h, chans;

        // Directed list, at the reset size of 256 x 256 and four channels.
        plan_cmd(make_item(bts_pkg::CMD_WRITE, 8'd0, 8'd0, 32'h00000000, '0, '0), 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd0, 8'd0, 32'hFFFFFFFF, '1, '1),
                 1, 32'h00000000);
        plan_cmd(make_item(bts_pkg::CMD_WRITE, 8'd255, 8'd255, 32'hFFFFFFFF, '1, '1),
                 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd255, 8'd255, 32'h0, '0, '0),
                 1, 32'hFFFFFFFF);
        plan_cmd(make_item(bts_pkg::CMD_WRITE, 8'd1, 8'd0, 32'h12345678, 16'h5A5A, 16'hA5A5),
                 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd1, 8'd0, 32'h0, '0, '0), 1, 32'h12345678);
        plan_cmd(make_item(bts_pkg::CMD_WRITE, 8'd0, 8'd1, 32'h80402010, '0, '0), 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_WRITE, 8'd1, 8'd1, 32'hFF00FF00, '0, '0), 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_SAMPLE, 8'hFF, 8'hFF, 32'hFFFFFFFF, '0, '0),
                 1, 32'h00000000);
        // The far corner: every neighbour clamps onto the last pixel.
        plan_cmd(make_item(bts_pkg::CMD_SAMPLE, 8'd0, 8'd0, 32'h0, '1, '1), 1, 32'hFFFFFFFF);
        plan_cmd(make_item(bts_pkg::CMD_SAMPLE, 8'd0, 8'd0, 32'h0, 16'h0080, 16'h0080),
                 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_SAMPLE, 8'd0, 8'd0, 32'h0, 16'h0040, 16'h00C0),
                 0, '0);
        plan_cmd(make_item(CMD_UNUSED, 8'hFF, 8'hFF, 32'hFFFFFFFF, '1, '1), 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_WRITE, 8'd255, 8'd0, 32'h01020304, '0, '0), 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd255, 8'd0, 32'h0, '0, '0), 1, 32'h01020304);
        // Missing channels read as zero, alpha as fully opaque.
        plan_reg(bts_pkg::REG_CHANNEL_COUNT, 32'd1);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd1, 8'd0, 32'h0, '0, '0), 1, 32'h120000FF);
        plan_reg(bts_pkg::REG_CHANNEL_COUNT, 32'd0);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd1, 8'd0, 32'h0, '0, '0), 1, 32'h120000FF);
        plan_reg(bts_pkg::REG_CHANNEL_COUNT, 32'd3);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd1, 8'd0, 32'h0, '0, '0), 1, 32'h123456FF);
        plan_reg(bts_pkg::REG_CHANNEL_COUNT, 32'd7);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd1, 8'd0, 32'h0, '0, '0), 1, 32'h12345678);
        // A zero size behaves as a single pixel, so everything lands on it.
        plan_reg(bts_pkg::REG_IMAGE_WIDTH, 32'd0);
        plan_reg(bts_pkg::REG_IMAGE_HEIGHT, 32'd0);
        plan_cmd(make_item(bts_pkg::CMD_WRITE, 8'd200, 8'd200, 32'h5AA53CC3, '0, '0), 0, '0);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd7, 8'd9, 32'h0, '0, '0), 1, 32'h5AA53CC3);
        plan_cmd(make_item(bts_pkg::CMD_SAMPLE, 8'd0, 8'd0, 32'h0, '1, 16'h1234),
                 1, 32'h5AA53CC3);
        // Oversized settings saturate to the full image.
        plan_reg(bts_pkg::REG_IMAGE_WIDTH, 32'd511);
        plan_reg(bts_pkg::REG_IMAGE_HEIGHT, 32'd300);
        plan_cmd(make_item(bts_pkg::CMD_READ, 8'd255, 8'd255, 32'h0, '0, '0),
                 1, 32'hFFFFFFFF);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_item(plan[k].item, plan[k].known, plan[k].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            gap_pct = (ph < 4) ? 14 : (ph < 8) ? 77 : 0;
            case (ph)
                0: begin
                    dim_w = MAX_W;
                    dim_h = MAX_H;
                    chans = bts_pkg::NUM_CHAN;
                end
                1: begin
                    dim_w = 1;
                    dim_h = 1;
                    chans = 1;
                end
                5: begin
                    dim_w = 2;
                    dim_h = 256;
                    chans = 2;
                end
                9: begin
                    dim_w = 255;
                    dim_h = 2;
                    chans = 3;
                end
                default: begin
                    dim_w = pick_dim();
                    dim_h = pick_dim();
                    chans = $urandom_range(7);
                end
            endcase
            settle();
            write_reg(bts_pkg::REG_IMAGE_WIDTH, dim_w);
            write_reg(bts_pkg::REG_IMAGE_HEIGHT, dim_h);
            write_reg(bts_pkg::REG_CHANNEL_COUNT, chans);
            phase_end = items_done + ITEMS_PER_PHASE;
            while (items_done < phase_end)
                send_with_fill(rand_item());
        end

        settle();
        $display("sent %0d items: %0d writes, %0d reads, %0d samples, %0d ignored",
                 items_done + ignored_done, writes_done, reads_done, samples_done,
                 ignored_done);
        $display("checked %0d colours over %0d register writes, %0d mismatches",
                 results_seen, settings_done, fault_count);
        if (fault_count == 0 && expected_colours.size() == 0)
            $display("bilinear_texel_sampler_unit test passed");
        else
            $display("bilinear_texel_sampler_unit test failed");
        $finish;
    end

endmodule

FILE: files.f
src/bts_pkg.sv
src/bts_ram.sv
src/bts_ctrl.sv
src/bts_dp.sv
src/bilinear_texel_sampler_unit.sv
dv/tb_top.sv
